/* rtl/core/iol_pkg.sv */
// shared types and constants for the indexed ordered list
`timescale 1ns / 1ps

package iol_pkg;

	localparam int CAPACITY_DEF = 64;
	localparam int OP_W         = 2;
	localparam int POS_W        = 7;
	localparam int DATA_W       = 32;
	localparam int LEN_W        = 7;
	localparam int STATUS_W     = 2;

	typedef enum logic [OP_W-1:0] {
		OP_APPEND = 2'd0,
		OP_INSERT = 2'd1,
		OP_DELETE = 2'd2,
		OP_READ   = 2'd3
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE   = 2'd0,
		ST_ZERO   = 2'd1,
		ST_BEYOND = 2'd2,
		ST_FULL   = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EVAL,
		S_RD_WAIT,
		S_SH_CHK,
		S_SH_RD,
		S_SH_WR,
		S_INS_WR,
		S_RESP
	} ctrl_state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic res_set;
		logic res_read;
		logic cur_init;
		logic rd_pos;
		logic rd_src;
		logic wr_src;
		logic wr_tail;
		logic wr_pos;
		logic cnt_inc;
		logic cnt_dec;
		logic out_load;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		op_t     op;
		status_t verdict;
		logic    more;
		logic    out_busy;
	} sts_t;

endpackage

/* rtl/core/iol_req_if.sv */
// request channel: operation, position and value
`timescale 1ns / 1ps

interface iol_req_if;
	logic                              valid;
	logic                              ready;
	logic [iol_pkg::OP_W-1:0]          op;
	logic [iol_pkg::POS_W-1:0]         position;
	logic signed [iol_pkg::DATA_W-1:0] value;

	modport source (output valid, output op, output position, output value, input ready);
	modport sink (input valid, input op, input position, input value, output ready);
endinterface

/* rtl/core/iol_rsp_if.sv */
// response channel: outcome, read word and list length
`timescale 1ns / 1ps

interface iol_rsp_if;
	logic                              valid;
	logic                              ready;
	logic                              ok;
	logic [iol_pkg::STATUS_W-1:0]      status;
	logic signed [iol_pkg::DATA_W-1:0] read_value;
	logic [iol_pkg::LEN_W-1:0]         length;

	modport source (output valid, output ok, output status, output read_value, output length,
		input ready);
	modport sink (input valid, input ok, input status, input read_value, input length,
		output ready);
endinterface

/* rtl/core/iol_ram.sv */
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps

module iol_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

/* rtl/core/iol_ctrl.sv */
// sequencing state machine for list operations
`timescale 1ns / 1ps

module iol_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  iol_pkg::sts_t sts,
	output iol_pkg::cmd_t cmd
);

	iol_pkg::ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= iol_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		case (state_q)
			iol_pkg::S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = iol_pkg::S_EVAL;
				end
			end
			iol_pkg::S_EVAL: begin
				cmd.res_set = 1'b1;
				if (sts.verdict != iol_pkg::ST_DONE) begin
					state_d = iol_pkg::S_RESP;
				end else begin
					case (sts.op)
						iol_pkg::OP_APPEND: begin
							cmd.wr_tail = 1'b1;
							cmd.cnt_inc = 1'b1;
							state_d     = iol_pkg::S_RESP;
						end
						iol_pkg::OP_READ: begin
							cmd.rd_pos = 1'b1;
							state_d    = iol_pkg::S_RD_WAIT;
						end
						default: begin
							cmd.cur_init = 1'b1;
							state_d      = iol_pkg::S_SH_CHK;
						end
					endcase
				end
			end
			iol_pkg::S_RD_WAIT: begin
				cmd.res_read = 1'b1;
				state_d      = iol_pkg::S_RESP;
			end
			iol_pkg::S_SH_CHK: begin
				if (sts.more) begin
					state_d = iol_pkg::S_SH_RD;
				end else if (sts.op == iol_pkg::OP_INSERT) begin
					state_d = iol_pkg::S_INS_WR;
				end else begin
					cmd.cnt_dec = 1'b1;
					state_d     = iol_pkg::S_RESP;
				end
			end
			iol_pkg::S_SH_RD: begin
				cmd.rd_src = 1'b1;
				state_d    = iol_pkg::S_SH_WR;
			end
			iol_pkg::S_SH_WR: begin
				cmd.wr_src = 1'b1;
				state_d    = iol_pkg::S_SH_CHK;
			end
			iol_pkg::S_INS_WR: begin
				cmd.wr_pos  = 1'b1;
				cmd.cnt_inc = 1'b1;
				state_d     = iol_pkg::S_RESP;
			end
			iol_pkg::S_RESP: begin
				if (!sts.out_busy) begin
					cmd.out_load = 1'b1;
					state_d      = iol_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = iol_pkg::S_IDLE;
			end
		endcase
	end

endmodule

/* rtl/core/iol_dp.sv */
// datapath: element memory, count, shift cursor and result registers
`timescale 1ns / 1ps

module iol_dp #(
	parameter int CAPACITY = iol_pkg::CAPACITY_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [iol_pkg::OP_W-1:0]          req_op,
	input  logic [iol_pkg::POS_W-1:0]         req_position,
	input  logic signed [iol_pkg::DATA_W-1:0] req_value,
	input  iol_pkg::cmd_t                     cmd,
	output iol_pkg::sts_t                     sts,
	iol_rsp_if.source                         rsp
);

	localparam int ADDR_W = $clog2(CAPACITY);
	localparam int CNT_W  = $clog2(CAPACITY + 1);
	localparam int CMP_W  = (CNT_W > iol_pkg::POS_W) ? CNT_W : iol_pkg::POS_W;

	iol_pkg::op_t                      op_q;
	logic [iol_pkg::POS_W-1:0]         pos_q;
	logic signed [iol_pkg::DATA_W-1:0] val_q;
	logic [CNT_W-1:0]                  count_q;
	logic [CNT_W-1:0]                  idx_q;
	iol_pkg::status_t                  res_status_q;
	logic signed [iol_pkg::DATA_W-1:0] res_rd_q;
	logic                              out_valid_q;
	iol_pkg::status_t                  out_status_q;
	logic signed [iol_pkg::DATA_W-1:0] out_rd_q;
	logic [iol_pkg::LEN_W-1:0]         out_len_q;

	logic [CMP_W-1:0]          count_x, pos_x, idx_x;
	logic                      full;
	iol_pkg::status_t          chk, verdict;
	logic                      more;
	logic                      wr_en, rd_en;
	logic [ADDR_W-1:0]         wr_addr, rd_addr;
	logic [iol_pkg::DATA_W-1:0] wr_data, rd_data;

	assign count_x = CMP_W'(count_q);
	assign pos_x   = CMP_W'(pos_q);
	assign idx_x   = CMP_W'(idx_q);
	assign full    = count_x >= CMP_W'(CAPACITY);

	always_comb begin
		if (pos_q == '0) begin
			chk = iol_pkg::ST_ZERO;
		end else if (pos_x > count_x) begin
			chk = iol_pkg::ST_BEYOND;
		end else begin
			chk = iol_pkg::ST_DONE;
		end

		// position checks come before the full check
		if (op_q == iol_pkg::OP_APPEND) begin
			verdict = full ? iol_pkg::ST_FULL : iol_pkg::ST_DONE;
		end else if (chk != iol_pkg::ST_DONE) begin
			verdict = chk;
		end else if (op_q == iol_pkg::OP_INSERT && full) begin
			verdict = iol_pkg::ST_FULL;
		end else begin
			verdict = iol_pkg::ST_DONE;
		end

		// insert walks down from the tail, delete walks up from the hole
		if (op_q == iol_pkg::OP_INSERT) begin
			more = idx_x > pos_x;
		end else begin
			more = (idx_x + CMP_W'(1)) < count_x;
		end
	end

	always_comb begin
		wr_en   = cmd.wr_tail | cmd.wr_pos | cmd.wr_src;
		wr_addr = ADDR_W'(idx_x);
		wr_data = rd_data;
		if (cmd.wr_tail) begin
			wr_addr = count_q[ADDR_W-1:0];
			wr_data = val_q;
		end else if (cmd.wr_pos) begin
			wr_addr = ADDR_W'(pos_x);
			wr_data = val_q;
		end

		rd_en = cmd.rd_pos | cmd.rd_src;
		if (cmd.rd_pos) begin
			rd_addr = ADDR_W'(pos_x - CMP_W'(1));
		end else if (op_q == iol_pkg::OP_INSERT) begin
			rd_addr = ADDR_W'(idx_x - CMP_W'(1));
		end else begin
			rd_addr = ADDR_W'(idx_x + CMP_W'(1));
		end
	end

	iol_ram #(
		.WIDTH(iol_pkg::DATA_W),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.cnt_inc) begin
				count_q <= count_q + CNT_W'(1);
			end else if (cmd.cnt_dec) begin
				count_q <= count_q - CNT_W'(1);
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= iol_pkg::op_t'(req_op);
			pos_q <= req_position;
			val_q <= req_value;
		end
		if (cmd.cur_init) begin
			idx_q <= (op_q == iol_pkg::OP_INSERT) ? count_q : CNT_W'(pos_x - CMP_W'(1));
		end else if (cmd.wr_src) begin
			idx_q <= (op_q == iol_pkg::OP_INSERT) ? idx_q - CNT_W'(1) : idx_q + CNT_W'(1);
		end
		if (cmd.res_set) begin
			res_status_q <= verdict;
			res_rd_q     <= '0;
		end else if (cmd.res_read) begin
			res_rd_q <= rd_data;
		end
		if (cmd.out_load) begin
			out_status_q <= res_status_q;
			out_rd_q     <= res_rd_q;
			out_len_q    <= count_x[iol_pkg::LEN_W-1:0];
		end
	end

	assign sts.op       = op_q;
	assign sts.verdict  = verdict;
	assign sts.more     = more;
	assign sts.out_busy = out_valid_q & ~rsp.ready;

	assign rsp.valid      = out_valid_q;
	assign rsp.ok         = out_status_q == iol_pkg::ST_DONE;
	assign rsp.status     = out_status_q;
	assign rsp.read_value = out_rd_q;
	assign rsp.length     = out_len_q;

endmodule

/* rtl/core/indexed_ordered_list.sv */
// top level of the indexed ordered list
`timescale 1ns / 1ps

// channel | dir | payload                            | handshake
// req     | in  | op, position, value                | valid/ready, taken on both high
// rsp     | out | ok, status, read_value, length     | valid/ready, taken on both high
//
// one item in flight; the controller sequences accesses to a single element ram
// append and rejected items pass the accept, evaluate and hand-off steps; a read adds a ram wait step
// insert and delete run a shift loop over the elements moved; a move is a check, a read, a write
// reset clears the count and the output valid flag; the element ram and result data are not cleared
// a finished result waits in the output register while the next item is accepted
// the next result stalls in its hand-off step until the waiting one is taken

module indexed_ordered_list #(
	parameter int CAPACITY = iol_pkg::CAPACITY_DEF
) (
	input logic       clk,
	input logic       arst_n,
	iol_req_if.sink   req,
	iol_rsp_if.source rsp
);

	// command and status between controller and datapath
	iol_pkg::cmd_t cmd;
	iol_pkg::sts_t sts;

	// state machine: accept, evaluate, shift loop, result hand-off
	iol_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req.valid),
		.req_ready(req.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// element storage, count, cursor and output register
	iol_dp #(
		.CAPACITY(CAPACITY)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_op      (req.op),
		.req_position(req.position),
		.req_value   (req.value),
		.cmd         (cmd),
		.sts         (sts),
		.rsp         (rsp)
	);

endmodule
